FILE: hdl/urb_pkg.sv
package urb_pkg;

    localparam int RX_DEPTH_DEF = 64;
    localparam int TX_DEPTH_DEF = 64;
    localparam int DATA_W       = 8;
    localparam int COUNT_W      = 6;
    localparam int PADDR_W      = 3;

    // Word index of the driver enable control register.
    localparam logic [PADDR_W-3:0] REG_USE_DE = 1'b0;

    typedef enum logic [2:0] {
        MODE_PUT      = 3'd0,
        MODE_GET      = 3'd1,
        MODE_RECEIVE  = 3'd2,
        MODE_TX_READY = 3'd3,
        MODE_TX_DONE  = 3'd4
    } mode_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    typedef struct packed {
        logic get_ok;
        logic was_empty;
        logic accepted;
        logic dropped;
        logic send_valid;
    } result_flags_t;

endpackage

FILE: hdl/urb_ring.sv
module urb_ring #(
    parameter int DEPTH = urb_pkg::RX_DEPTH_DEF,
    parameter int PTR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic                      pop,
    input  logic [urb_pkg::DATA_W-1:0] wdata,
    output logic [urb_pkg::DATA_W-1:0] rdata,
    output urb_pkg::ring_stat_t       stat,
    output logic [PTR_W-1:0]          count
);

    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);

    logic [urb_pkg::DATA_W-1:0] mem [DEPTH];
    logic [urb_pkg::DATA_W-1:0] rdata_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_next;
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           wr_ptr_next;
    logic [PTR_W-1:0]           wr_ptr_inc;
    logic [PTR_W-1:0]           rd_ptr_inc;
    logic [PTR_W:0]             diff;

    assign wr_ptr_inc = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;

    assign stat.empty = (wr_ptr_reg == rd_ptr_reg);
    assign stat.full  = (wr_ptr_inc == rd_ptr_reg);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_inc : rd_ptr_reg;
    end

    // Fill level with wrap for depths that are not a power of two.
    always_comb
    begin
        if (wr_ptr_reg >= rd_ptr_reg)
        begin
            diff = {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg};
        end
        else
        begin
            diff = {1'b0, wr_ptr_reg} + DEPTH_EXT - {1'b0, rd_ptr_reg};
        end
    end

    assign count = diff[PTR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
        if (pop)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/uart_ring_buffer_rs485_unit.sv
// UART ring-buffer unit with RS-485 driver enable. Each event is taken when start is high
// and busy is low; busy stays low, so a new event can be issued every clock cycle. The
// result of an event appears on the result ports for exactly one cycle, the cycle right
// after the event was taken, marked by strobe, and the receiver must take it then. The
// delay is the synchronous read of the receive or transmit ring memory.
// Each ring holds DEPTH-1 bytes; rx_count is the receive fill level modulo 64.
module uart_ring_buffer_rs485_unit #(
    parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = urb_pkg::TX_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   mode,
    input  logic [urb_pkg::DATA_W-1:0]   data_byte,
    input  logic                         rx_error,
    output logic                         strobe,
    output logic [urb_pkg::DATA_W-1:0]   read_byte,
    output logic                         rx_was_empty,
    output logic                         put_accepted,
    output logic                         rx_dropped,
    output logic [urb_pkg::DATA_W-1:0]   send_byte,
    output logic                         send_valid,
    output logic                         tx_request,
    output logic                         driver_enable,
    output logic [urb_pkg::COUNT_W-1:0]  rx_count,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [urb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);

    logic                          accept;
    logic                          cfg_write;
    logic                          use_de_reg;
    logic                          tx_irq_reg;
    logic                          tx_irq_next;
    logic                          drive_reg;
    logic                          drive_next;
    logic                          pend_valid_reg;
    urb_pkg::result_flags_t        pend_reg;
    urb_pkg::result_flags_t        flags_next;
    logic                          rx_push;
    logic                          rx_pop;
    logic                          tx_push;
    logic                          tx_pop;
    logic [urb_pkg::DATA_W-1:0]    rx_rdata;
    logic [urb_pkg::DATA_W-1:0]    tx_rdata;
    urb_pkg::ring_stat_t           rx_stat;
    urb_pkg::ring_stat_t           tx_stat;
    logic [RX_PTR_W-1:0]           rx_fill;
    logic [TX_PTR_W-1:0]           tx_fill;
    logic [RX_PTR_W+urb_pkg::COUNT_W-1:0] rx_fill_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[urb_pkg::PADDR_W-1:2] == urb_pkg::REG_USE_DE);

    always_comb
    begin
        prdata = '0;
        if (paddr[urb_pkg::PADDR_W-1:2] == urb_pkg::REG_USE_DE)
        begin
            prdata[0] = use_de_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_de_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            use_de_reg <= pwdata[0];
        end
    end

    // Event decode.
    always_comb
    begin
        flags_next  = '0;
        rx_push     = 1'b0;
        rx_pop      = 1'b0;
        tx_push     = 1'b0;
        tx_pop      = 1'b0;
        tx_irq_next = tx_irq_reg;
        drive_next  = drive_reg;
        if (accept)
        begin
            case (urb_pkg::mode_t'(mode))
                urb_pkg::MODE_PUT:
                begin
                    if (!tx_stat.full)
                    begin
                        tx_push             = 1'b1;
                        tx_irq_next         = 1'b1;
                        flags_next.accepted = 1'b1;
                    end
                end
                urb_pkg::MODE_GET:
                begin
                    if (!rx_stat.empty)
                    begin
                        rx_pop            = 1'b1;
                        flags_next.get_ok = 1'b1;
                    end
                    else
                    begin
                        flags_next.was_empty = 1'b1;
                    end
                end
                urb_pkg::MODE_RECEIVE:
                begin
                    if (!rx_error && !rx_stat.full)
                    begin
                        rx_push = 1'b1;
                    end
                    else
                    begin
                        flags_next.dropped = 1'b1;
                    end
                end
                urb_pkg::MODE_TX_READY:
                begin
                    if (!tx_stat.empty)
                    begin
                        tx_pop                = 1'b1;
                        flags_next.send_valid = 1'b1;
                        if (use_de_reg)
                        begin
                            drive_next = 1'b1;
                        end
                    end
                    else
                    begin
                        tx_irq_next = 1'b0;
                    end
                end
                urb_pkg::MODE_TX_DONE:
                begin
                    if (use_de_reg)
                    begin
                        drive_next = 1'b0;
                    end
                end
                default:
                begin
                    flags_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_irq_reg     <= 1'b0;
            drive_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            tx_irq_reg     <= tx_irq_next;
            drive_reg      <= drive_next;
            pend_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= flags_next;
    end

    urb_ring #(
        .DEPTH (RX_DEPTH),
        .PTR_W (RX_PTR_W)
    ) u_rx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rx_push),
        .pop   (rx_pop),
        .wdata (data_byte),
        .rdata (rx_rdata),
        .stat  (rx_stat),
        .count (rx_fill)
    );

    urb_ring #(
        .DEPTH (TX_DEPTH),
        .PTR_W (TX_PTR_W)
    ) u_tx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tx_push),
        .pop   (tx_pop),
        .wdata (data_byte),
        .rdata (tx_rdata),
        .stat  (tx_stat),
        .count (tx_fill)
    );

    // The result beat is built from the registered event flags, the memory read data and
    // the state registers, which already hold the values after the event.
    assign rx_fill_ext   = {{urb_pkg::COUNT_W{1'b0}}, rx_fill};
    assign strobe        = pend_valid_reg;
    assign read_byte     = (pend_valid_reg && pend_reg.get_ok) ? rx_rdata : '0;
    assign rx_was_empty  = pend_valid_reg && pend_reg.was_empty;
    assign put_accepted  = pend_valid_reg && pend_reg.accepted;
    assign rx_dropped    = pend_valid_reg && pend_reg.dropped;
    assign send_valid    = pend_valid_reg && pend_reg.send_valid;
    assign send_byte     = send_valid ? tx_rdata : '0;
    assign tx_request    = tx_irq_reg;
    assign driver_enable = drive_reg;
    assign rx_count      = rx_fill_ext[urb_pkg::COUNT_W-1:0];

`ifndef SYNTHESIS
    a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy))
        else $error("result beat without a preceding accepted event");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({pend_reg.get_ok, pend_reg.was_empty, pend_reg.accepted,
                  pend_reg.dropped, pend_reg.send_valid}) || !pend_valid_reg)
        else $error("more than one event outcome in one result beat");

    a_tx_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(tx_stat.empty && tx_stat.full) && !(rx_stat.empty && rx_stat.full))
        else $error("ring reported empty and full at once");

    a_send_pops: assert property (@(posedge clk) disable iff (!rst_n)
        tx_pop |=> (send_valid && (tx_fill != $past(tx_fill) || TX_DEPTH == 2)))
        else $error("transmit pop did not produce a send beat");
`endif

endmodule
